### design/kst_pkg.sv
// kst_pkg: shared types and constants for the keyed handle slot table
// used by keyed_handle_slot_table and its testbench; no dependencies
package kst_pkg;

   localparam int CAPACITY = 64;
   localparam int GEN_BITS = 16;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int ID_W     = 32;
   localparam int REV_W    = 16;

   // request kinds
   localparam logic [1:0] KIND_UPSERT   = 2'd0;
   localparam logic [1:0] KIND_REMOVE   = 2'd1;
   localparam logic [1:0] KIND_FIND_ID  = 2'd2;
   localparam logic [1:0] KIND_FIND_HDL = 2'd3;

   // response status codes
   localparam logic [2:0] ST_ADDED    = 3'd0;
   localparam logic [2:0] ST_UPDATED  = 3'd1;
   localparam logic [2:0] ST_REMOVED  = 3'd2;
   localparam logic [2:0] ST_FOUND    = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;
   localparam logic [2:0] ST_ZEROID   = 3'd5;
   localparam logic [2:0] ST_MISMATCH = 3'd6;
   localparam logic [2:0] ST_FULL     = 3'd7;

   // sorted id index entry
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [ADDR_W-1:0] slot;
   } key_entry_type;

   // handle slot entry: alive bit and generation
   typedef struct packed {
      logic                alive;
      logic [GEN_BITS-1:0] gen;
   } slot_entry_type;

   // dense record entry
   typedef struct packed {
      logic [ADDR_W-1:0] slot;
      logic              dim;
      logic [REV_W-1:0]  rev;
   } record_entry_type;

endpackage

### design/kst_ram.sv
// kst_ram: generic simple dual-port RAM, one write and one registered read port
// no package dependencies
module kst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/keyed_handle_slot_table.sv
// keyed_handle_slot_table: record table keyed by nonzero id, with sorted index,
// generational handle slots, free-slot stack and dense records; uses kst_pkg, kst_ram
//
//   channel | ports                        | handshake
//   --------+------------------------------+-------------------------------------
//   request | req_kind .. req_handle_gen.. | word taken when start && !busy
//   result  | rsp_status .. rsp_clip_count | rsp_valid high one cycle per word
//
// one word at a time; busy stays high from acceptance until all table updates end,
// except for words answered at once; a lookup by id runs one binary-search step per
// key RAM read, then reads the key, slot and record; a lookup by handle reads the
// slot and record or answers at once; insert and erase shift the key RAM one entry
// per cycle
// synchronous reset empties the table at once; no clearing pass is needed
// the receiver cannot stall: each result word is shown for exactly one cycle
module keyed_handle_slot_table
   import kst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_kind,
   input  logic [31:0]         req_clip_id,
   input  logic                req_dimension,
   input  logic [7:0]          req_handle_index,
   input  logic [15:0]         req_handle_generation,
   output logic                rsp_valid,
   output logic [2:0]          rsp_status,
   output logic [5:0]          rsp_slot_index,
   output logic [15:0]         rsp_slot_generation,
   output logic                rsp_record_dimension,
   output logic [15:0]         rsp_record_revision,
   output logic [5:0]          rsp_record_position,
   output logic [6:0]          rsp_clip_count
);

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_SEARCH = 13'b0000000000010,
      S_CMP    = 13'b0000000000100,
      S_HIT    = 13'b0000000001000,
      S_MISS   = 13'b0000000010000,
      S_SLOT   = 13'b0000000100000,
      S_REC    = 13'b0000001000000,
      S_MOVE   = 13'b0000010000000,
      S_POP    = 13'b0000100000000,
      S_GEN    = 13'b0001000000000,
      S_ALLOC  = 13'b0010000000000,
      S_SHIFT  = 13'b0100000000000,
      S_KEYW   = 13'b1000000000000
   } state_type;

   // control registers
   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] rec_count_ff, rec_count_in;
   logic [COUNT_W-1:0] slot_count_ff, slot_count_in;
   logic [COUNT_W-1:0] free_count_ff, free_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               pend_ff, pend_in;

   // working registers
   logic [1:0]          kind_ff, kind_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic                dim_ff, dim_in;
   logic [GEN_BITS-1:0] hgen_ff, hgen_in;
   logic [COUNT_W-1:0]  first_ff, first_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic [COUNT_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic [ADDR_W-1:0]   slot_ff, slot_in;
   logic [GEN_BITS-1:0] gen_ff, gen_in;
   logic [ADDR_W-1:0]   rec_ff, rec_in;

   // result registers
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [GEN_BITS-1:0] rsp_gen_ff, rsp_gen_in;
   logic                rsp_dim_ff, rsp_dim_in;
   logic [REV_W-1:0]    rsp_rev_ff, rsp_rev_in;
   logic [ADDR_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // memory ports
   logic               key_we, slot_we, srec_we, rec_we, free_we;
   logic [ADDR_W-1:0]  key_waddr, slot_waddr, srec_waddr, rec_waddr, free_waddr;
   logic [ADDR_W-1:0]  key_raddr, slot_raddr, rec_raddr, free_raddr;
   key_entry_type      key_wdata, key_rdata;
   slot_entry_type     slot_wdata, slot_rdata;
   logic [ADDR_W-1:0]  srec_wdata, srec_rdata;
   record_entry_type   rec_wdata, rec_rdata;
   logic [ADDR_W-1:0]  free_wdata, free_rdata;

   // search helpers
   logic [COUNT_W-1:0] half;
   logic [COUNT_W-1:0] mid;
   logic [COUNT_W-1:0] key_ra_wide;
   logic               erase;

   assign half  = cnt_ff >> 1;
   assign mid   = first_ff + half;
   assign erase = (kind_ff == KIND_REMOVE);

   kst_ram #(.WIDTH($bits(key_entry_type)), .DEPTH(CAPACITY)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_waddr), .wr_data(key_wdata),
      .rd_addr(key_raddr), .rd_data(key_rdata)
   );

   kst_ram #(.WIDTH($bits(slot_entry_type)), .DEPTH(CAPACITY)) u_slot_ram (
      .clock(clock), .wr_en(slot_we), .wr_addr(slot_waddr), .wr_data(slot_wdata),
      .rd_addr(slot_raddr), .rd_data(slot_rdata)
   );

   kst_ram #(.WIDTH(ADDR_W), .DEPTH(CAPACITY)) u_srec_ram (
      .clock(clock), .wr_en(srec_we), .wr_addr(srec_waddr), .wr_data(srec_wdata),
      .rd_addr(slot_raddr), .rd_data(srec_rdata)
   );

   kst_ram #(.WIDTH($bits(record_entry_type)), .DEPTH(CAPACITY)) u_rec_ram (
      .clock(clock), .wr_en(rec_we), .wr_addr(rec_waddr), .wr_data(rec_wdata),
      .rd_addr(rec_raddr), .rd_data(rec_rdata)
   );

   kst_ram #(.WIDTH(ADDR_W), .DEPTH(CAPACITY)) u_free_ram (
      .clock(clock), .wr_en(free_we), .wr_addr(free_waddr), .wr_data(free_wdata),
      .rd_addr(free_raddr), .rd_data(free_rdata)
   );

   // read address selection
   always_comb begin
      if (state_ff == S_SHIFT) begin
         key_ra_wide = erase ? idx_ff + 1'b1 : idx_ff - 1'b1;
      end else if (state_ff == S_SEARCH && cnt_ff != '0) begin
         key_ra_wide = mid;
      end else begin
         key_ra_wide = first_ff;
      end
   end
   assign key_raddr  = key_ra_wide[ADDR_W-1:0];
   assign free_raddr = ADDR_W'(free_count_ff - 1'b1);

   always_comb begin
      unique case (state_ff)
         S_IDLE:  slot_raddr = req_handle_index[ADDR_W-1:0];
         S_HIT:   slot_raddr = key_rdata.slot;
         S_POP:   slot_raddr = free_rdata;
         default: slot_raddr = slot_ff;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         S_SLOT:  rec_raddr = srec_rdata;
         default: rec_raddr = ADDR_W'(rec_count_ff - 1'b1);
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      rec_count_in  = rec_count_ff;
      slot_count_in = slot_count_ff;
      free_count_in = free_count_ff;
      pend_in       = pend_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      dim_in        = dim_ff;
      hgen_in       = hgen_ff;
      first_in      = first_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      pend_addr_in  = pend_addr_ff;
      slot_in       = slot_ff;
      gen_in        = gen_ff;
      rec_in        = rec_ff;

      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_gen_in    = rsp_gen_ff;
      rsp_dim_in    = rsp_dim_ff;
      rsp_rev_in    = rsp_rev_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;

      key_we     = 1'b0;
      key_waddr  = pend_addr_ff;
      key_wdata  = key_rdata;
      slot_we    = 1'b0;
      slot_waddr = slot_ff;
      slot_wdata = '{alive: 1'b0, gen: gen_ff + 1'b1};
      srec_we    = 1'b0;
      srec_waddr = slot_ff;
      srec_wdata = rec_ff;
      rec_we     = 1'b0;
      rec_waddr  = rec_ff;
      rec_wdata  = rec_rdata;
      free_we    = 1'b0;
      free_waddr = free_count_ff[ADDR_W-1:0];
      free_wdata = slot_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               id_in    = req_clip_id;
               dim_in   = req_dimension;
               hgen_in  = req_handle_generation;
               first_in = '0;
               cnt_in   = rec_count_ff;
               slot_in  = req_handle_index[ADDR_W-1:0];
               // empty result word unless a record is found later
               rsp_status_in = ST_NOTFOUND;
               rsp_slot_in   = '0;
               rsp_gen_in    = '0;
               rsp_dim_in    = 1'b0;
               rsp_rev_in    = '0;
               rsp_pos_in    = '0;
               rsp_count_in  = rec_count_ff;
               if (req_kind == KIND_FIND_HDL) begin
                  if ({1'b0, req_handle_index} < {{(9-COUNT_W){1'b0}}, slot_count_ff}) begin
                     state_in = S_SLOT;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end else if (req_clip_id == '0) begin
                  rsp_status_in = ST_ZEROID;
                  rsp_valid_in  = 1'b1;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end

         // lower bound: issue a probe or finish
         S_SEARCH: begin
            if (cnt_ff == '0) begin
               state_in = (first_ff < rec_count_ff) ? S_HIT : S_MISS;
            end else begin
               state_in = S_CMP;
            end
         end

         S_CMP: begin
            if (key_rdata.id < id_ff) begin
               first_in = mid + 1'b1;
               cnt_in   = cnt_ff - half - 1'b1;
            end else begin
               cnt_in = half;
            end
            state_in = S_SEARCH;
         end

         // check the key at the lower bound
         S_HIT: begin
            if (key_rdata.id == id_ff) begin
               slot_in  = key_rdata.slot;
               state_in = S_SLOT;
            end else begin
               state_in = S_MISS;
            end
         end

         // id absent: report or allocate
         S_MISS: begin
            if (kind_ff != KIND_UPSERT) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (rec_count_ff >= COUNT_W'(CAPACITY)) begin
               rsp_status_in = ST_FULL;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (free_count_ff != '0) begin
               free_count_in = free_count_ff - 1'b1;
               state_in      = S_POP;
            end else if (slot_count_ff < COUNT_W'(CAPACITY)) begin
               slot_in       = slot_count_ff[ADDR_W-1:0];
               gen_in        = GEN_BITS'(1);
               slot_count_in = slot_count_ff + 1'b1;
               state_in      = S_ALLOC;
            end else begin
               rsp_status_in = ST_FULL;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end

         // slot word arrives; record read goes out
         S_SLOT: begin
            gen_in = slot_rdata.gen;
            rec_in = srec_rdata;
            if (kind_ff == KIND_FIND_HDL &&
                (!slot_rdata.alive || slot_rdata.gen != hgen_ff ||
                 {1'b0, srec_rdata} >= rec_count_ff)) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_REC;
            end
         end

         S_REC: begin
            rsp_slot_in  = slot_ff;
            rsp_gen_in   = gen_ff;
            rsp_dim_in   = rec_rdata.dim;
            rsp_rev_in   = rec_rdata.rev;
            rsp_pos_in   = rec_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            unique case (kind_ff)
               KIND_FIND_ID, KIND_FIND_HDL: begin
                  rsp_status_in = ST_FOUND;
               end
               KIND_REMOVE: begin
                  rsp_status_in = ST_REMOVED;
                  rsp_count_in  = rec_count_ff - 1'b1;
                  rec_count_in  = rec_count_ff - 1'b1;
                  // kill slot, bump generation, push on free stack
                  slot_we = 1'b1;
                  if (free_count_ff < COUNT_W'(CAPACITY)) begin
                     free_we       = 1'b1;
                     free_count_in = free_count_ff + 1'b1;
                  end
                  idx_in  = first_ff;
                  pend_in = 1'b0;
                  if ({1'b0, rec_ff} != rec_count_ff - 1'b1) begin
                     state_in = S_MOVE;
                  end else begin
                     state_in = S_SHIFT;
                  end
               end
               default: begin
                  if (rec_rdata.dim != dim_ff) begin
                     rsp_status_in = ST_MISMATCH;
                  end else begin
                     rsp_status_in = ST_UPDATED;
                     rsp_rev_in    = rec_rdata.rev + 1'b1;
                     rec_we        = 1'b1;
                     rec_wdata     = '{slot: rec_rdata.slot, dim: rec_rdata.dim,
                                       rev: rec_rdata.rev + 1'b1};
                  end
               end
            endcase
         end

         // swap the last record into the hole
         S_MOVE: begin
            rec_we     = 1'b1;
            srec_we    = 1'b1;
            srec_waddr = rec_rdata.slot;
            state_in   = S_SHIFT;
         end

         S_POP: begin
            slot_in  = free_rdata;
            state_in = S_GEN;
         end

         S_GEN: begin
            gen_in   = slot_rdata.gen;
            state_in = S_ALLOC;
         end

         // claim slot and record, then open a gap in the index
         S_ALLOC: begin
            slot_we       = 1'b1;
            slot_wdata    = '{alive: 1'b1, gen: gen_ff};
            srec_we       = 1'b1;
            srec_wdata    = rec_count_ff[ADDR_W-1:0];
            rec_we        = 1'b1;
            rec_waddr     = rec_count_ff[ADDR_W-1:0];
            rec_wdata     = '{slot: slot_ff, dim: dim_ff, rev: REV_W'(1)};
            rec_in        = rec_count_ff[ADDR_W-1:0];
            rec_count_in  = rec_count_ff + 1'b1;
            idx_in        = rec_count_ff;
            pend_in       = 1'b0;
            state_in      = S_SHIFT;
         end

         // one index entry moves per cycle, read then write
         S_SHIFT: begin
            key_we = pend_ff;
            if (erase ? (idx_ff < rec_count_ff) : (idx_ff > first_ff)) begin
               pend_in      = 1'b1;
               pend_addr_in = idx_ff[ADDR_W-1:0];
               idx_in       = erase ? idx_ff + 1'b1 : idx_ff - 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = erase ? S_IDLE : S_KEYW;
               end
            end
         end

         S_KEYW: begin
            key_we        = 1'b1;
            key_waddr     = first_ff[ADDR_W-1:0];
            key_wdata     = '{id: id_ff, slot: slot_ff};
            rsp_status_in = ST_ADDED;
            rsp_slot_in   = slot_ff;
            rsp_gen_in    = gen_ff;
            rsp_dim_in    = dim_ff;
            rsp_rev_in    = REV_W'(1);
            rsp_pos_in    = rec_ff;
            rsp_count_in  = rec_count_ff;
            rsp_valid_in  = 1'b1;
            state_in      = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rec_count_ff  <= '0;
         slot_count_ff <= '0;
         free_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rec_count_ff  <= rec_count_in;
         slot_count_ff <= slot_count_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_ff       <= pend_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      dim_ff        <= dim_in;
      hgen_ff       <= hgen_in;
      first_ff      <= first_in;
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      pend_addr_ff  <= pend_addr_in;
      slot_ff       <= slot_in;
      gen_ff        <= gen_in;
      rec_ff        <= rec_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_gen_ff    <= rsp_gen_in;
      rsp_dim_ff    <= rsp_dim_in;
      rsp_rev_ff    <= rsp_rev_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_slot_index       = rsp_slot_ff;
   assign rsp_slot_generation  = rsp_gen_ff;
   assign rsp_record_dimension = rsp_dim_ff;
   assign rsp_record_revision  = rsp_rev_ff;
   assign rsp_record_position  = rsp_pos_ff;
   assign rsp_clip_count       = rsp_count_ff;

endmodule

### verif/keyed_handle_slot_table_tb.sv
// keyed_handle_slot_table_tb: drives upsert, remove and find words into the slot table
// and checks every result word against a behavioral table model; uses kst_pkg
module keyed_handle_slot_table_tb;
   import kst_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = KIND_UPSERT;
   logic [31:0] req_clip_id = '0;
   logic        req_dimension = 1'b0;
   logic [7:0]  req_handle_index = '0;
   logic [15:0] req_handle_generation = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_slot_index;
   logic [15:0] rsp_slot_generation;
   logic        rsp_record_dimension;
   logic [15:0] rsp_record_revision;
   logic [5:0]  rsp_record_position;
   logic [6:0]  rsp_clip_count;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  slot;
      logic [15:0] gen;
      logic        dim;
      logic [15:0] rev;
      logic [5:0]  pos;
      logic [6:0]  count;
   } answer_type;

   localparam int WATCHDOG_LIMIT = 2000;

   keyed_handle_slot_table i_dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // table model state
   logic [31:0] m_key_id [CAPACITY];
   logic [5:0]  m_key_slot [CAPACITY];
   int          m_key_count;
   logic        m_alive [CAPACITY];
   logic [15:0] m_gen [CAPACITY];
   int          m_slot_rec [CAPACITY];
   int          m_slot_count;
   logic [5:0]  m_free [CAPACITY];
   int          m_free_count;
   logic [5:0]  m_rec_slot [CAPACITY];
   logic        m_rec_dim [CAPACITY];
   logic [15:0] m_rec_rev [CAPACITY];
   int          m_rec_count;

   answer_type  pending_answers [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   bit          calm = 1'b0;
   logic [31:0] live_ids [$];

   function automatic answer_type make_answer(logic [2:0] st, int slot, bit with_rec);
      answer_type a;
      a = '0;
      a.status = st;
      if (with_rec) begin
         a.slot = slot[5:0];
         a.gen = m_gen[slot];
         a.dim = m_rec_dim[m_slot_rec[slot]];
         a.rev = m_rec_rev[m_slot_rec[slot]];
         a.pos = m_slot_rec[slot][5:0];
      end
      a.count = m_rec_count[6:0];
      return a;
   endfunction

   // applies one word to the model and returns its answer
   function automatic answer_type table_apply(logic [1:0] kind, logic [31:0] id, logic dim,
                                              logic [7:0] hidx, logic [15:0] hgen);
      int pos, slot, rec, last, i, lo, n, half;
      bit hit;
      answer_type a;
      if (kind == KIND_FIND_HDL) begin
         if (hidx < m_slot_count && m_alive[hidx] && m_gen[hidx] == hgen &&
             m_slot_rec[hidx] < m_rec_count)
            return make_answer(ST_FOUND, hidx, 1);
         return make_answer(ST_NOTFOUND, 0, 0);
      end
      if (id == 0) return make_answer(ST_ZEROID, 0, 0);
      // lower bound search
      lo = 0;
      n = m_key_count;
      while (n > 0) begin
         half = n / 2;
         if (m_key_id[lo + half] < id) begin
            lo = lo + half + 1;
            n = n - half - 1;
         end else begin
            n = half;
         end
      end
      pos = lo;
      hit = pos < m_key_count && m_key_id[pos] == id;
      slot = hit ? m_key_slot[pos] : 0;
      if (kind == KIND_FIND_ID)
         return hit ? make_answer(ST_FOUND, slot, 1) : make_answer(ST_NOTFOUND, 0, 0);
      if (kind == KIND_REMOVE) begin
         if (!hit) return make_answer(ST_NOTFOUND, 0, 0);
         a = make_answer(ST_REMOVED, slot, 1);
         rec = m_slot_rec[slot];
         last = m_rec_count - 1;
         if (rec != last) begin
            m_rec_slot[rec] = m_rec_slot[last];
            m_rec_dim[rec] = m_rec_dim[last];
            m_rec_rev[rec] = m_rec_rev[last];
            m_slot_rec[m_rec_slot[rec]] = rec;
         end
         m_rec_count = last;
         m_alive[slot] = 1'b0;
         m_gen[slot] = m_gen[slot] + 16'd1;
         if (m_free_count < CAPACITY) begin
            m_free[m_free_count] = slot[5:0];
            m_free_count++;
         end
         for (i = pos; i + 1 < m_key_count; i++) begin
            m_key_id[i] = m_key_id[i + 1];
            m_key_slot[i] = m_key_slot[i + 1];
         end
         m_key_count--;
         a.count = m_rec_count[6:0];
         return a;
      end
      // upsert
      if (hit) begin
         rec = m_slot_rec[slot];
         if (m_rec_dim[rec] != dim) return make_answer(ST_MISMATCH, slot, 1);
         m_rec_rev[rec] = m_rec_rev[rec] + 16'd1;
         return make_answer(ST_UPDATED, slot, 1);
      end
      if (m_rec_count >= CAPACITY) return make_answer(ST_FULL, 0, 0);
      if (m_free_count > 0) begin
         m_free_count--;
         slot = m_free[m_free_count];
      end else if (m_slot_count < CAPACITY) begin
         slot = m_slot_count;
         m_slot_count++;
         m_gen[slot] = 16'd1;
      end else begin
         return make_answer(ST_FULL, 0, 0);
      end
      m_alive[slot] = 1'b1;
      rec = m_rec_count;
      m_rec_count++;
      m_slot_rec[slot] = rec;
      m_rec_slot[rec] = slot[5:0];
      m_rec_dim[rec] = dim;
      m_rec_rev[rec] = 16'd1;
      for (i = m_key_count; i > pos; i--) begin
         m_key_id[i] = m_key_id[i - 1];
         m_key_slot[i] = m_key_slot[i - 1];
      end
      m_key_id[pos] = id;
      m_key_slot[pos] = slot[5:0];
      m_key_count++;
      return make_answer(ST_ADDED, slot, 1);
   endfunction

   // send one word, keeping the model's live-id list for later picks
   task automatic send_word(logic [1:0] kind, logic [31:0] id, logic dim,
                            logic [7:0] hidx, logic [15:0] hgen);
      answer_type a;
      int k;
      while (!calm && $urandom_range(99) < 6) @(posedge clock);
      start <= 1'b1;
      req_kind <= kind;
      req_clip_id <= id;
      req_dimension <= dim;
      req_handle_index <= hidx;
      req_handle_generation <= hgen;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      a = table_apply(kind, id, dim, hidx, hgen);
      pending_answers = {pending_answers, a};
      if (a.status == ST_ADDED) live_ids = {live_ids, id};
      if (a.status == ST_REMOVED)
         for (k = 0; k < live_ids.size(); k++)
            if (live_ids[k] == id) begin
               live_ids.delete(k);
               break;
            end
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_id();
      if (live_ids.size() != 0 && $urandom_range(3) != 0)
         return live_ids[$urandom_range(live_ids.size() - 1)];
      case ($urandom_range(3))
         0: return $urandom_range(7);
         1: return 32'hFFFF_FFF0 | $urandom_range(15);
         default: return $urandom;
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_slot_index, rsp_slot_generation, rsp_record_dimension,
                rsp_record_revision, rsp_record_position, rsp_clip_count};
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
         end else begin
            want = pending_answers.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("mismatch: expected st%0d sl%0d g%0d d%0d r%0d p%0d c%0d,",
                         want.status, want.slot, want.gen, want.dim, want.rev, want.pos,
                         want.count);
                  $display(" got st%0d sl%0d g%0d d%0d r%0d p%0d c%0d",
                           got.status, got.slot, got.gen, got.dim, got.rev,
                           got.pos, got.count);
               end
            end
         end
      end
   end

   // watchdog on cycles with no accepted word and no result word
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // zero ids, misses, extremes of every field
   task automatic test_directed();
      send_word(KIND_FIND_ID, 32'd5, 1'b0, 8'd0, 16'd0);
      send_word(KIND_REMOVE, 32'd5, 1'b0, 8'd0, 16'd0);
      send_word(KIND_FIND_HDL, 32'd0, 1'b0, 8'd0, 16'd0);
      send_word(KIND_UPSERT, 32'd0, 1'b1, 8'hFF, 16'hFFFF);
      send_word(KIND_REMOVE, 32'd0, 1'b0, 8'd0, 16'd0);
      send_word(KIND_FIND_ID, 32'd0, 1'b0, 8'd0, 16'd0);
      send_word(KIND_UPSERT, 32'hFFFF_FFFF, 1'b1, 8'd0, 16'd0);
      send_word(KIND_UPSERT, 32'd1, 1'b0, 8'd0, 16'd0);
      send_word(KIND_UPSERT, 32'h8000_0000, 1'b0, 8'd0, 16'd0);
      send_word(KIND_UPSERT, 32'd1, 1'b0, 8'd0, 16'd0);
      send_word(KIND_UPSERT, 32'd1, 1'b1, 8'd0, 16'd0);
      send_word(KIND_FIND_HDL, 32'd0, 1'b0, 8'd1, 16'd1);
      send_word(KIND_FIND_HDL, 32'd0, 1'b0, 8'd1, 16'd2);
      send_word(KIND_FIND_HDL, 32'd0, 1'b0, 8'hFF, 16'hFFFF);
      send_word(KIND_REMOVE, 32'hFFFF_FFFF, 1'b0, 8'd0, 16'd0);
      send_word(KIND_FIND_HDL, 32'd0, 1'b0, 8'd0, 16'd1);
      send_word(KIND_FIND_ID, 32'h8000_0000, 1'b0, 8'd0, 16'd0);
      send_word(KIND_UPSERT, 32'h7FFF_FFFF, 1'b1, 8'd0, 16'd0);
      send_word(KIND_FIND_HDL, 32'd0, 1'b0, 8'd0, 16'd2);
      drain();
   endtask

   // fill to capacity, hit full, then remove in random order down to eight live ids
   task automatic test_full_table();
      int k;
      k = 0;
      while (m_rec_count < CAPACITY && k < 200) begin
         send_word(KIND_UPSERT, $urandom | 32'd1, 1'($urandom_range(1)), 8'd0, 16'd0);
         k++;
      end
      send_word(KIND_UPSERT, $urandom | 32'd1, 1'b0, 8'd0, 16'd0);
      send_word(KIND_UPSERT, live_ids[0], m_rec_dim[0], 8'd0, 16'd0);
      drain();
      while (live_ids.size() > 8)
         send_word(KIND_REMOVE, live_ids[$urandom_range(live_ids.size() - 1)], 1'b0,
                   8'd0, 16'd0);
      drain();
   endtask

   // random mix biased toward live ids and valid handles
   task automatic test_random(int words, bit quiet);
      int n, r, h;
      calm = quiet;
      for (n = 0; n < words; n++) begin
         r = $urandom_range(99);
         h = $urandom_range(63);
         if (r < 35)
            send_word(KIND_UPSERT, pick_id(), 1'($urandom_range(1)), 8'($urandom),
                      16'($urandom));
         else if (r < 55)
            send_word(KIND_REMOVE, pick_id(), 1'($urandom_range(1)), 8'($urandom),
                      16'($urandom));
         else if (r < 75)
            send_word(KIND_FIND_ID, pick_id(), 1'($urandom_range(1)), 8'($urandom),
                      16'($urandom));
         else if (r < 92)
            send_word(KIND_FIND_HDL, $urandom, 1'($urandom_range(1)), h[7:0],
                      m_gen[h] + ($urandom_range(3) == 0 ? 16'd1 : 16'd0));
         else
            send_word(KIND_FIND_HDL, $urandom, 1'($urandom_range(1)), 8'($urandom),
                      16'($urandom));
      end
      calm = 1'b0;
   endtask

   initial begin
      m_key_count = 0;
      m_slot_count = 0;
      m_free_count = 0;
      m_rec_count = 0;
      // generations of unused slots start at zero
      foreach (m_gen[g]) m_gen[g] = 16'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_random(500, 1'b0);
      drain();
      test_random(200, 1'b1);
      test_full_table();
      test_random(300, 1'b0);
      drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
